FILE: rtl/prb_pkg.sv
`timescale 1ns / 1ps
// Package for the polyline ribbon extruder: beat types, job type, state enums and helpers.
// No dependencies; every other file in rtl/ uses it by scoped names.
package prb_pkg;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int WIDTH_BITS = 31;
   localparam int DIR_BITS   = COORD_BITS + 1;
   localparam int MAG_BITS   = 34;
   localparam int UNIT_BITS  = FRAC_BITS + 2;
   localparam int SQ_BITS    = 62;
   localparam int ROOT_BITS  = 31;

   localparam logic [4:0] SQRT_STEPS = 5'd31;
   localparam logic [4:0] DIV_STEPS  = 5'd17;

   localparam logic [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
      logic [30:0]        ribbon_width;
      logic               first_point;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic               side;
      logic               strip_end;
   } rsp_type;

   typedef struct packed {
      logic [2:0][COORD_BITS-1:0] pos;
      logic [2:0][DIR_BITS-1:0]   dir;
      logic [2:0][COORD_BITS-1:0] nrm;
      logic [WIDTH_BITS-1:0]      width;
      logic                       strip_end;
   } job_type;

   typedef enum logic [1:0] {
      VEC_DIR,
      VEC_NRM,
      VEC_CRS
   } vec_sel_type;

   typedef enum logic [3:0] {
      CORE_IDLE,
      CORE_SHIFT,
      CORE_SQ_MUL,
      CORE_SQ_ACC,
      CORE_SQRT_GO,
      CORE_SQRT_WAIT,
      CORE_DIV_GO,
      CORE_DIV_WAIT,
      CORE_X_MUL,
      CORE_X_ACC,
      CORE_H_MUL,
      CORE_H_ACC,
      CORE_OUT_MINUS,
      CORE_OUT_PLUS
   } core_state_type;

   typedef enum logic {
      TOP_IDLE,
      TOP_FLUSH
   } top_state_type;

   // Cross product term order: c0 = d1*n2 - d2*n1, c1 = d2*n0 - d0*n2, c2 = d0*n1 - d1*n0.
   function automatic logic [1:0] cross_d_index(input logic [2:0] j);
      logic [1:0] r;
      case (j)
         3'd0: r = 2'd1;
         3'd1: r = 2'd2;
         3'd2: r = 2'd2;
         3'd3: r = 2'd0;
         3'd4: r = 2'd0;
         3'd5: r = 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] cross_n_index(input logic [2:0] j);
      logic [1:0] r;
      case (j)
         3'd0: r = 2'd2;
         3'd1: r = 2'd1;
         3'd2: r = 2'd0;
         3'd3: r = 2'd2;
         3'd4: r = 2'd1;
         3'd5: r = 2'd0;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   // Center plus or minus the offset, saturated to the signed coordinate range.
   function automatic logic [COORD_BITS-1:0] vertex_calc(input logic [COORD_BITS-1:0] p,
                                                         input logic [COORD_BITS-1:0] h,
                                                         input logic plus);
      logic [COORD_BITS:0] s;
      logic [COORD_BITS-1:0] r;
      if (plus) begin
         s = {p[COORD_BITS-1], p} + {h[COORD_BITS-1], h};
      end else begin
         s = {p[COORD_BITS-1], p} - {h[COORD_BITS-1], h};
      end
      if (s[COORD_BITS] != s[COORD_BITS-1]) begin
         r = s[COORD_BITS] ? SAT_MIN : SAT_MAX;
      end else begin
         r = s[COORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/polyline_ribbon_extruder_top.sv
`timescale 1ns / 1ps
// Polyline ribbon extruder: each point beat yields up to four strip vertices, Q16.16.
// The top level holds the polyline state; one output register carries the result beats.
// A point that emits a pair of vertices keeps the block busy until both vertex beats are
// registered, and longer when a result beat is stalled; a last point emits two pairs. The
// time is set by the shared square-root and divide unit, which produces one bit per cycle:
// each normalization of a nonzero vector takes a 31-step root, three 17-step divides and
// the squares, plus up to 29 one-bit alignment shifts, while a zero vector skips them;
// cross product and offsets use one multiplier, and the two vertex beats come last. A point
// that only opens a polyline emits nothing.
module polyline_ribbon_extruder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  prb_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prb_pkg::rsp_type  rsp_data
);

   localparam int CB = prb_pkg::COORD_BITS;

   prb_pkg::top_state_type      tstate_ff, tstate_in;
   logic [2:0][CB-1:0]          prev_ff, prev_in;
   logic [2:0][CB-1:0]          center_ff, center_in;
   logic [2:0][CB-1:0]          cnorm_ff, cnorm_in;
   logic [prb_pkg::WIDTH_BITS-1:0] cwidth_ff, cwidth_in;
   logic [1:0]                  seen_ff, seen_in;

   logic [2:0][CB-1:0]          in_pos;
   logic [2:0][CB-1:0]          in_nrm;
   logic                        accept;
   logic                        core_idle;
   logic                        job_start;
   prb_pkg::job_type            job;

   assign in_pos = {req_data.pos_z, req_data.pos_y, req_data.pos_x};
   assign in_nrm = {req_data.norm_z, req_data.norm_y, req_data.norm_x};
   assign req_ready = (tstate_ff == prb_pkg::TOP_IDLE) && core_idle;
   assign accept = req_valid && req_ready;

   always_comb begin
      tstate_in = tstate_ff;
      prev_in   = prev_ff;
      center_in = center_ff;
      cnorm_in  = cnorm_ff;
      cwidth_in = cwidth_ff;
      seen_in   = seen_ff;
      job_start = 1'b0;
      job.pos       = center_ff;
      job.nrm       = cnorm_ff;
      job.width     = cwidth_ff;
      job.strip_end = 1'b0;
      for (int i = 0; i < 3; i++) begin
         job.dir[i] = {center_ff[i][CB-1], center_ff[i]} - {prev_ff[i][CB-1], prev_ff[i]};
      end

      case (tstate_ff)
         prb_pkg::TOP_IDLE: begin
            if (accept) begin
               if (req_data.first_point || (seen_ff == 2'd0)) begin
                  if (req_data.last_point) begin
                     seen_in = 2'd0;
                  end else begin
                     center_in = in_pos;
                     cnorm_in  = in_nrm;
                     cwidth_in = req_data.ribbon_width;
                     seen_in   = 2'd1;
                  end
               end else begin
                  job_start = 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     job.dir[i] = {in_pos[i][CB-1], in_pos[i]} -
                        ((seen_ff == 2'd1) ? {center_ff[i][CB-1], center_ff[i]}
                                           : {prev_ff[i][CB-1], prev_ff[i]});
                  end
                  prev_in   = center_ff;
                  center_in = in_pos;
                  cnorm_in  = in_nrm;
                  cwidth_in = req_data.ribbon_width;
                  seen_in   = 2'd2;
                  if (req_data.last_point) begin
                     tstate_in = prb_pkg::TOP_FLUSH;
                  end
               end
            end
         end
         prb_pkg::TOP_FLUSH: begin
            job.strip_end = 1'b1;
            if (core_idle) begin
               job_start = 1'b1;
               seen_in   = 2'd0;
               tstate_in = prb_pkg::TOP_IDLE;
            end
         end
         default: begin
            tstate_in = prb_pkg::TOP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tstate_ff <= prb_pkg::TOP_IDLE;
         seen_ff   <= 2'd0;
         prev_ff   <= '0;
         center_ff <= '0;
         cnorm_ff  <= '0;
         cwidth_ff <= '0;
      end else begin
         tstate_ff <= tstate_in;
         seen_ff   <= seen_in;
         prev_ff   <= prev_in;
         center_ff <= center_in;
         cnorm_ff  <= cnorm_in;
         cwidth_ff <= cwidth_in;
      end
   end

   prb_core u_core (
      .clock     (clock),
      .reset     (reset),
      .job_start (job_start),
      .job       (job),
      .core_idle (core_idle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_accept_core_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> core_idle)
      else $error("Point beat accepted while the core was busy.");

   a_flush_has_pred: assert property (@(posedge clock) disable iff (reset)
      (tstate_ff == prb_pkg::TOP_FLUSH) |-> (seen_ff == 2'd2))
      else $error("Flush pending without a held point and predecessor.");

   a_end_on_plus: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.strip_end) |-> rsp_data.side)
      else $error("Strip end marked on a minus-side vertex.");

   a_flush_follows_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.last_point && !req_data.first_point &&
       (seen_ff != 2'd0)) |=> (tstate_ff == prb_pkg::TOP_FLUSH))
      else $error("Last point did not schedule the final vertex pair.");

endmodule

FILE: rtl/prb_isqdiv.sv
`timescale 1ns / 1ps
// Shared iterative unit: floor square root or restoring division, one result bit per cycle.
// Depends on prb_pkg.
module prb_isqdiv (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              sqrt_mode,
   input  logic [prb_pkg::SQ_BITS-1:0]       radicand,
   input  logic [29:0]                       dividend,
   input  logic [prb_pkg::ROOT_BITS-1:0]     divisor,
   output logic [prb_pkg::ROOT_BITS-1:0]     result,
   output logic                              done
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic                              mode_ff, mode_in;
   logic [4:0]                        cnt_ff, cnt_in;
   logic [33:0]                       rem_ff, rem_in;
   logic [prb_pkg::ROOT_BITS-1:0]     root_ff, root_in;
   logic [prb_pkg::SQ_BITS-1:0]       src_ff, src_in;
   logic [prb_pkg::ROOT_BITS-1:0]     dvs_ff, dvs_in;
   logic [33:0]                       cur;
   logic [33:0]                       trial;
   logic                              fits;

   always_comb begin
      if (mode_ff) begin
         cur   = {rem_ff[31:0], src_ff[61:60]};
         trial = {1'b0, root_ff, 2'b01};
      end else begin
         cur   = {rem_ff[32:0], src_ff[61]};
         trial = {3'b000, dvs_ff};
      end
      fits = (cur >= trial);

      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      src_in  = src_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         mode_in = sqrt_mode;
         root_in = '0;
         dvs_in  = divisor;
         if (sqrt_mode) begin
            rem_in = '0;
            src_in = radicand;
            cnt_in = prb_pkg::SQRT_STEPS;
         end else begin
            rem_in = {5'b00000, dividend[29:1]};
            src_in = {dividend[0], {(prb_pkg::SQ_BITS-1){1'b0}}};
            cnt_in = prb_pkg::DIV_STEPS;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? (cur - trial) : cur;
         root_in = {root_ff[prb_pkg::ROOT_BITS-2:0], fits};
         src_in  = mode_ff ? {src_ff[59:0], 2'b00} : {src_ff[60:0], 1'b0};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mode_ff <= mode_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      src_ff  <= src_in;
      dvs_ff  <= dvs_in;
   end

   assign result = root_ff;
   assign done   = done_ff;

endmodule

FILE: rtl/prb_core.sv
`timescale 1ns / 1ps
// Vertex-pair sequencer: three normalizations, cross product and offsets on one multiplier
// and one square-root/divide unit. Depends on prb_pkg and prb_isqdiv.
module prb_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_start,
   input  prb_pkg::job_type  job,
   output logic              core_idle,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prb_pkg::rsp_type  rsp_data
);

   localparam int CB = prb_pkg::COORD_BITS;
   localparam int MB = prb_pkg::MAG_BITS;
   localparam int UB = prb_pkg::UNIT_BITS;
   localparam int DIR_W = prb_pkg::DIR_BITS;

   prb_pkg::core_state_type     state_ff, state_in;
   prb_pkg::vec_sel_type        tgt_ff, tgt_in;
   logic [2:0][CB-1:0]          pos_ff, pos_in;
   logic [2:0][CB-1:0]          nrm_ff, nrm_in;
   logic [prb_pkg::WIDTH_BITS-1:0] width_ff, width_in;
   logic                        end_ff, end_in;
   logic [2:0][MB-1:0]          m_ff, m_in;
   logic [2:0]                  neg_ff, neg_in;
   logic [1:0]                  idx_ff, idx_in;
   logic [2:0]                  jsel_ff, jsel_in;
   logic [prb_pkg::SQ_BITS-1:0] acc_ff, acc_in;
   logic [prb_pkg::ROOT_BITS-1:0] len_ff, len_in;
   logic signed [63:0]          prod_ff, prod_in;
   logic [2:0][UB-1:0]          d_ff, d_in;
   logic [2:0][UB-1:0]          n_ff, n_in;
   logic [2:0][UB-1:0]          cu_ff, cu_in;
   logic [2:0][CB-1:0]          h_ff, h_in;
   logic [35:0]                 ctmp_ff, ctmp_in;
   logic                        out_valid_ff, out_valid_in;
   prb_pkg::rsp_type            out_ff, out_in;

   logic [MB-1:0]               mx01, mx;
   logic signed [31:0]          mul_a, mul_b;
   logic [UB-1:0]               cu_abs;
   logic [UB-1:0]               uval;
   logic [35:0]                 xdiff;
   logic [35:0]                 xmag;
   logic [30:0]                 hmag;
   logic [DIR_W-1:0]            dir_mag;
   logic [CB-1:0]               nrm_mag;
   logic                        unit_start;
   logic                        unit_sqrt;
   logic [prb_pkg::ROOT_BITS-1:0] unit_result;
   logic                        unit_done;
   logic                        out_free;
   logic                        finish_norm;
   logic [1:0]                  xd, xn;

   prb_isqdiv u_isqdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (unit_start),
      .sqrt_mode (unit_sqrt),
      .radicand  (acc_ff),
      .dividend  (m_ff[idx_ff][29:0]),
      .divisor   (len_ff),
      .result    (unit_result),
      .done      (unit_done)
   );

   always_comb begin
      mx01 = (m_ff[0] > m_ff[1]) ? m_ff[0] : m_ff[1];
      mx   = (mx01 > m_ff[2]) ? mx01 : m_ff[2];
      xd   = prb_pkg::cross_d_index(jsel_ff);
      xn   = prb_pkg::cross_n_index(jsel_ff);
      cu_abs = cu_ff[idx_ff][UB-1] ? (UB'(0) - cu_ff[idx_ff]) : cu_ff[idx_ff];
      uval = neg_ff[idx_ff] ? (UB'(0) - {1'b0, unit_result[UB-2:0]})
                            : {1'b0, unit_result[UB-2:0]};
      xdiff = ctmp_ff - prod_ff[35:0];
      xmag  = xdiff[35] ? (36'd0 - xdiff) : xdiff;
      hmag  = prod_ff[47:17];
      out_free = !out_valid_ff || rsp_ready;

      case (state_ff)
         prb_pkg::CORE_SQ_MUL: begin
            mul_a = {2'b00, m_ff[idx_ff][29:0]};
            mul_b = {2'b00, m_ff[idx_ff][29:0]};
         end
         prb_pkg::CORE_X_MUL: begin
            mul_a = {{(32-UB){d_ff[xd][UB-1]}}, d_ff[xd]};
            mul_b = {{(32-UB){n_ff[xn][UB-1]}}, n_ff[xn]};
         end
         prb_pkg::CORE_H_MUL: begin
            mul_a = {{(32-UB+1){1'b0}}, cu_abs[UB-2:0]};
            mul_b = {1'b0, width_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;

      state_in     = state_ff;
      tgt_in       = tgt_ff;
      pos_in       = pos_ff;
      nrm_in       = nrm_ff;
      width_in     = width_ff;
      end_in       = end_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      idx_in       = idx_ff;
      jsel_in      = jsel_ff;
      acc_in       = acc_ff;
      len_in       = len_ff;
      d_in         = d_ff;
      n_in         = n_ff;
      cu_in        = cu_ff;
      h_in         = h_ff;
      ctmp_in      = ctmp_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      unit_start   = 1'b0;
      unit_sqrt    = 1'b0;
      finish_norm  = 1'b0;
      dir_mag      = '0;
      nrm_mag      = '0;

      case (state_ff)
         prb_pkg::CORE_IDLE: begin
            if (job_start) begin
               pos_in   = job.pos;
               nrm_in   = job.nrm;
               width_in = job.width;
               end_in   = job.strip_end;
               tgt_in   = prb_pkg::VEC_DIR;
               for (int i = 0; i < 3; i++) begin
                  dir_mag   = job.dir[i][DIR_W-1] ? (DIR_W'(0) - job.dir[i]) : job.dir[i];
                  neg_in[i] = job.dir[i][DIR_W-1];
                  m_in[i]   = MB'(dir_mag);
               end
               state_in = prb_pkg::CORE_SHIFT;
            end
         end
         prb_pkg::CORE_SHIFT: begin
            if (mx == '0) begin
               for (int i = 0; i < 3; i++) begin
                  case (tgt_ff)
                     prb_pkg::VEC_DIR: d_in[i]  = '0;
                     prb_pkg::VEC_NRM: n_in[i]  = '0;
                     default:          cu_in[i] = '0;
                  endcase
               end
               finish_norm = 1'b1;
            end else if (mx[MB-1:30] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = {1'b0, m_ff[i][MB-1:1]};
               end
            end else if (!mx[29]) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = {m_ff[i][MB-2:0], 1'b0};
               end
            end else begin
               acc_in   = '0;
               idx_in   = 2'd0;
               state_in = prb_pkg::CORE_SQ_MUL;
            end
         end
         prb_pkg::CORE_SQ_MUL: begin
            state_in = prb_pkg::CORE_SQ_ACC;
         end
         prb_pkg::CORE_SQ_ACC: begin
            acc_in = acc_ff + prod_ff[prb_pkg::SQ_BITS-1:0];
            if (idx_ff == 2'd2) begin
               state_in = prb_pkg::CORE_SQRT_GO;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = prb_pkg::CORE_SQ_MUL;
            end
         end
         prb_pkg::CORE_SQRT_GO: begin
            unit_start = 1'b1;
            unit_sqrt  = 1'b1;
            state_in   = prb_pkg::CORE_SQRT_WAIT;
         end
         prb_pkg::CORE_SQRT_WAIT: begin
            if (unit_done) begin
               len_in   = unit_result;
               idx_in   = 2'd0;
               state_in = prb_pkg::CORE_DIV_GO;
            end
         end
         prb_pkg::CORE_DIV_GO: begin
            unit_start = 1'b1;
            state_in   = prb_pkg::CORE_DIV_WAIT;
         end
         prb_pkg::CORE_DIV_WAIT: begin
            if (unit_done) begin
               case (tgt_ff)
                  prb_pkg::VEC_DIR: d_in[idx_ff]  = uval;
                  prb_pkg::VEC_NRM: n_in[idx_ff]  = uval;
                  default:          cu_in[idx_ff] = uval;
               endcase
               if (idx_ff == 2'd2) begin
                  finish_norm = 1'b1;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = prb_pkg::CORE_DIV_GO;
               end
            end
         end
         prb_pkg::CORE_X_MUL: begin
            state_in = prb_pkg::CORE_X_ACC;
         end
         prb_pkg::CORE_X_ACC: begin
            if (!jsel_ff[0]) begin
               ctmp_in  = prod_ff[35:0];
               jsel_in  = jsel_ff + 3'd1;
               state_in = prb_pkg::CORE_X_MUL;
            end else begin
               m_in[jsel_ff[2:1]]   = xmag[MB-1:0];
               neg_in[jsel_ff[2:1]] = xdiff[35];
               if (jsel_ff == 3'd5) begin
                  tgt_in   = prb_pkg::VEC_CRS;
                  state_in = prb_pkg::CORE_SHIFT;
               end else begin
                  jsel_in  = jsel_ff + 3'd1;
                  state_in = prb_pkg::CORE_X_MUL;
               end
            end
         end
         prb_pkg::CORE_H_MUL: begin
            state_in = prb_pkg::CORE_H_ACC;
         end
         prb_pkg::CORE_H_ACC: begin
            h_in[idx_ff] = cu_ff[idx_ff][UB-1] ? (CB'(0) - {1'b0, hmag}) : {1'b0, hmag};
            if (idx_ff == 2'd2) begin
               state_in = prb_pkg::CORE_OUT_MINUS;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = prb_pkg::CORE_H_MUL;
            end
         end
         prb_pkg::CORE_OUT_MINUS: begin
            if (out_free) begin
               out_valid_in     = 1'b1;
               out_in.vert_x    = prb_pkg::vertex_calc(pos_ff[0], h_ff[0], 1'b0);
               out_in.vert_y    = prb_pkg::vertex_calc(pos_ff[1], h_ff[1], 1'b0);
               out_in.vert_z    = prb_pkg::vertex_calc(pos_ff[2], h_ff[2], 1'b0);
               out_in.side      = 1'b0;
               out_in.strip_end = 1'b0;
               state_in         = prb_pkg::CORE_OUT_PLUS;
            end
         end
         prb_pkg::CORE_OUT_PLUS: begin
            if (out_free) begin
               out_valid_in     = 1'b1;
               out_in.vert_x    = prb_pkg::vertex_calc(pos_ff[0], h_ff[0], 1'b1);
               out_in.vert_y    = prb_pkg::vertex_calc(pos_ff[1], h_ff[1], 1'b1);
               out_in.vert_z    = prb_pkg::vertex_calc(pos_ff[2], h_ff[2], 1'b1);
               out_in.side      = 1'b1;
               out_in.strip_end = end_ff;
               state_in         = prb_pkg::CORE_IDLE;
            end
         end
         default: begin
            state_in = prb_pkg::CORE_IDLE;
         end
      endcase

      if (finish_norm) begin
         case (tgt_ff)
            prb_pkg::VEC_DIR: begin
               tgt_in = prb_pkg::VEC_NRM;
               for (int i = 0; i < 3; i++) begin
                  nrm_mag   = nrm_ff[i][CB-1] ? (CB'(0) - nrm_ff[i]) : nrm_ff[i];
                  neg_in[i] = nrm_ff[i][CB-1];
                  m_in[i]   = MB'(nrm_mag);
               end
               state_in = prb_pkg::CORE_SHIFT;
            end
            prb_pkg::VEC_NRM: begin
               jsel_in  = 3'd0;
               state_in = prb_pkg::CORE_X_MUL;
            end
            default: begin
               idx_in   = 2'd0;
               state_in = prb_pkg::CORE_H_MUL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prb_pkg::CORE_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      tgt_ff   <= tgt_in;
      pos_ff   <= pos_in;
      nrm_ff   <= nrm_in;
      width_ff <= width_in;
      end_ff   <= end_in;
      m_ff     <= m_in;
      neg_ff   <= neg_in;
      idx_ff   <= idx_in;
      jsel_ff  <= jsel_in;
      acc_ff   <= acc_in;
      len_ff   <= len_in;
      prod_ff  <= prod_in;
      d_ff     <= d_in;
      n_ff     <= n_in;
      cu_ff    <= cu_in;
      h_ff     <= h_in;
      ctmp_ff  <= ctmp_in;
      out_ff   <= out_in;
   end

   assign core_idle = (state_ff == prb_pkg::CORE_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the polyline ribbon extruder: random and directed point beats.
// Depends on prb_pkg and polyline_ribbon_extruder_top; vertices are predicted in Q16.16.
module tb_top;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   prb_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   prb_pkg::rsp_type rsp_data;

   polyline_ribbon_extruder_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   prb_pkg::req_type point_queue[$];
   prb_pkg::rsp_type vertex_queue[$];
   int         errors = 0;
   int         vertices_seen = 0;
   int         points_sent = 0;
   int         send_gap = 0;
   int         recv_gap = 0;
   int         long_hold = 0;
   bit         hold_request = 0;
   bit         wait_drain = 0;
   bit         drain_seen = 0;

   // Predictor state for the held point and its predecessor.
   longint     held_prev[3];
   longint     held_pos[3];
   longint     held_nrm[3];
   longint     held_width;
   int         held_count;

   function automatic longint unsigned root64(input longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic normalize(input longint v[3], output longint u[3]);
      longint unsigned m[3], mx, s, len, q;
      bit ng[3];
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         ng[i] = v[i] < 0;
         m[i] = ng[i] ? -v[i] : v[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) u[i] = 0;
         return;
      end
      while (mx >= (64'd1 << 30)) begin
         mx = mx >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (mx < (64'd1 << 29)) begin
         mx = mx << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
      len = root64(s);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] << prb_pkg::FRAC_BITS) / len;
         u[i] = ng[i] ? -longint'(q) : longint'(q);
      end
   endtask

   function automatic logic [31:0] clamp32(input longint x);
      if (x > 64'sd2147483647) return 32'h7fffffff;
      if (x < -64'sd2147483648) return 32'h80000000;
      return x[31:0];
   endfunction

   task automatic expect_pair(input longint p[3], input longint dir[3], input longint nv[3],
                              input longint w, input bit last_pair);
      longint d[3], n[3], c[3], cu[3], h[3];
      longint unsigned mg;
      prb_pkg::rsp_type r;
      normalize(dir, d);
      normalize(nv, n);
      c[0] = d[1] * n[2] - d[2] * n[1];
      c[1] = d[2] * n[0] - d[0] * n[2];
      c[2] = d[0] * n[1] - d[1] * n[0];
      normalize(c, cu);
      for (int i = 0; i < 3; i++) begin
         mg = cu[i] < 0 ? -cu[i] : cu[i];
         h[i] = longint'((mg * longint'(w)) >> (prb_pkg::FRAC_BITS + 1));
         if (cu[i] < 0) h[i] = -h[i];
      end
      for (int s = 0; s < 2; s++) begin
         r.vert_x = clamp32(s ? p[0] + h[0] : p[0] - h[0]);
         r.vert_y = clamp32(s ? p[1] + h[1] : p[1] - h[1]);
         r.vert_z = clamp32(s ? p[2] + h[2] : p[2] - h[2]);
         r.side = s[0];
         r.strip_end = last_pair && s == 1;
         vertex_queue.push_back(r);
      end
   endtask

   task automatic predict_point(input prb_pkg::req_type t);
      longint p[3], n[3], dir[3];
      p[0] = longint'(t.pos_x); p[1] = longint'(t.pos_y); p[2] = longint'(t.pos_z);
      n[0] = longint'(t.norm_x); n[1] = longint'(t.norm_y); n[2] = longint'(t.norm_z);
      if (t.first_point || held_count == 0) begin
         if (t.last_point) begin
            held_count = 0;
            return;
         end
         held_pos = p;
         held_nrm = n;
         held_width = longint'(t.ribbon_width);
         held_count = 1;
         return;
      end
      for (int i = 0; i < 3; i++)
         dir[i] = p[i] - (held_count == 1 ? held_pos[i] : held_prev[i]);
      expect_pair(held_pos, dir, held_nrm, held_width, 1'b0);
      held_prev = held_pos;
      held_pos = p;
      held_nrm = n;
      held_width = longint'(t.ribbon_width);
      held_count = 2;
      if (t.last_point) begin
         for (int i = 0; i < 3; i++) dir[i] = held_pos[i] - held_prev[i];
         expect_pair(held_pos, dir, held_nrm, held_width, 1'b1);
         held_count = 0;
      end
   endtask

   // Driver: one beat per queue entry, random gap before each new beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_point(req_data);
            points_sent <= points_sent + 1;
         end
         if (req_valid && !req_ready) begin
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (wait_drain && vertex_queue.size() != 0) begin
            req_valid <= 1'b0;
            drain_seen <= 1'b1;
         end else if (point_queue.size() != 0) begin
            req_data <= point_queue.pop_front();
            req_valid <= 1'b1;
            send_gap <= (point_queue.size() == 0) ? 0 : int'($urandom_range(0, 5));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            vertices_seen <= vertices_seen + 1;
            if (vertex_queue.size() == 0) begin
               $display("%0t: unexpected vertex %p", $time, rsp_data);
               errors <= errors + 1;
            end else if (vertex_queue[0] !== rsp_data) begin
               $display("%0t: mismatch expected %p actual %p", $time, vertex_queue[0],
                        rsp_data);
               errors <= errors + 1;
               void'(vertex_queue.pop_front());
            end else begin
               void'(vertex_queue.pop_front());
            end
         end
         if (hold_request && long_hold == 0) begin
            long_hold <= 6000;
            hold_request <= 1'b0;
            rsp_ready <= 1'b0;
         end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            rsp_ready <= long_hold == 1;
         end else if (rsp_valid && rsp_ready || !rsp_ready) begin
            if (recv_gap > 0) begin
               rsp_ready <= 1'b0;
               recv_gap <= recv_gap - 1;
            end else begin
               rsp_ready <= 1'b1;
               recv_gap <= $urandom_range(0, 5);
            end
         end
      end
   end

   function automatic prb_pkg::req_type point_at(input longint x, input longint y,
                                                 input longint z, input bit f, input bit l);
      prb_pkg::req_type t;
      t.pos_x = 32'(x); t.pos_y = 32'(y); t.pos_z = 32'(z);
      t.norm_x = 0; t.norm_y = 0; t.norm_z = 32'sh0001_0000;
      t.ribbon_width = 31'h0002_0000;
      t.first_point = f;
      t.last_point = l;
      return t;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         2: return 32'($signed($urandom_range(0, 8192)) - 4096) << 12;
         default: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
      endcase
   endfunction

   function automatic prb_pkg::req_type rand_point(input bit f, input bit l);
      prb_pkg::req_type t;
      t.pos_x = rand_coord(); t.pos_y = rand_coord(); t.pos_z = rand_coord();
      t.norm_x = rand_coord(); t.norm_y = rand_coord(); t.norm_z = rand_coord();
      if ($urandom_range(0, 9) == 0) t.norm_x = 0;
      t.ribbon_width = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
      t.first_point = f;
      t.last_point = l;
      return t;
   endfunction

   initial begin
      int len, wait_cycles;
      prb_pkg::req_type t;
      held_count = 0;
      held_width = 0;
      for (int i = 0; i < 3; i++) begin
         held_prev[i] = 0; held_pos[i] = 0; held_nrm[i] = 0;
      end
      // Directed: lone point, zero direction, zero normal, extremes, restart, no-first start.
      point_queue.push_back(point_at(0, 0, 0, 1, 1));
      point_queue.push_back(point_at(32'sh0001_0000, 0, 0, 1, 0));
      point_queue.push_back(point_at(32'sh0001_0000, 0, 0, 0, 0));
      point_queue.push_back(point_at(32'sh0003_0000, 0, 0, 0, 1));
      t = point_at(32'sh7fffffff, 32'sh80000000, 0, 1, 0);
      t.ribbon_width = 31'h7fffffff;
      point_queue.push_back(t);
      t = point_at(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
      t.norm_x = 32'sh7fffffff; t.norm_y = 32'sh80000000; t.norm_z = 32'sh80000000;
      t.ribbon_width = 31'h7fffffff;
      point_queue.push_back(t);
      t = point_at(0, 0, 32'sh0001_0000, 0, 1);
      t.norm_z = 0;
      point_queue.push_back(t);
      point_queue.push_back(point_at(5, 6, 7, 1, 0));
      point_queue.push_back(point_at(9, 9, 9, 1, 0));
      point_queue.push_back(point_at(1, 2, 3, 0, 1));
      point_queue.push_back(point_at(4, 4, 4, 0, 0));
      point_queue.push_back(point_at(32'shffff_0000, 4, 4, 0, 1));
      point_queue.push_back(rand_point(1, 0));
      point_queue.push_back(rand_point(0, 1));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (point_queue.size() == 0);
      // Sender pauses until every expected vertex has arrived.
      wait_drain = 1;
      for (int k = 0; k < 245; k += len) begin
         len = $urandom_range(1, 6);
         for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 9) == 0)
               point_queue.push_back(rand_point($urandom_range(0, 1), $urandom_range(0, 1)));
            else
               point_queue.push_back(rand_point(j == 0, j == len - 1));
         end
         if (k == 0) begin
            wait (drain_seen && vertex_queue.size() == 0);
            wait_drain = 0;
            hold_request = 1;
         end
         wait (point_queue.size() < 4);
      end
      wait (point_queue.size() == 0);
      @(posedge clock);
      wait (!req_valid);
      wait_cycles = 0;
      while (vertex_queue.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (1000) @(posedge clock);
      $display("Sent %0d point beats and checked %0d vertex beats.", points_sent,
               vertices_seen);
      if (errors == 0 && vertex_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("status: fail");
      $finish;
   end
endmodule

FILE: files.f
rtl/prb_pkg.sv
rtl/prb_isqdiv.sv
rtl/prb_core.sv
rtl/polyline_ribbon_extruder_top.sv
tb/sv/tb_top.sv
